[hdl/bav_pkg.sv]
// package for the barometric altitude block: widths, register indexes,
// controller states, command/status structs and the log2/exp2 tables
// no dependencies
package bav_pkg;

  localparam int LOG_TBL_BITS = 8;
  localparam int TBL_SIZE     = (1 << LOG_TBL_BITS) + 1;
  localparam int FRAC_SH      = 16 - LOG_TBL_BITS;

  localparam int DIV_N_W   = 42;
  localparam int DIV_D_W   = 30;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [17:0] RATIO_MAX = 18'h3FFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SEA_LEVEL   = 3'd0,
    REG_ALT_SCALE   = 3'd1,
    REG_EXPONENT    = 3'd2,
    REG_CAL_SAMPLES = 3'd3,
    REG_RATIO_LOW   = 3'd4,
    REG_RATIO_HIGH  = 3'd5
  } reg_idx_t;

  localparam int CMD_RESTART = 1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_AVG_LOAD,
    ST_AVG_DIV,
    ST_GND_LOAD,
    ST_GND_DIV,
    ST_RATIO_DIV,
    ST_SAT,
    ST_POW_A,
    ST_POW_B,
    ST_POW_C,
    ST_POW_D,
    ST_POW_E,
    ST_POW_F,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_frame;
    logic restart;
    logic zero_alt;
    logic accum;
    logic load_avg_div;
    logic load_gnd_div;
    logic load_ratio_div;
    logic div_step;
    logic load_ratio;
    logic pow_a;
    logic pow_b;
    logic pow_c;
    logic pow_d;
    logic pow_e;
    logic pow_f;
    logic commit_ground;
    logic commit_alt;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic restart_cmd;
    logic p_zero;
    logic calibrated;
    logic cal_done;
    logic div_last;
    logic in_band;
  } dp_stat_t;

  typedef logic [17:0] tbl_t [TBL_SIZE];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v_in;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2 of 1 + i/N in Q.16, by repeated squaring
  function automatic tbl_t build_log_tab();
    tbl_t t;
    logic [63:0] x;
    logic [17:0] r;
    for (int i = 0; i < TBL_SIZE; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - LOG_TBL_BITS));
      r = 18'd0;
      if (x >= (64'd2 << 30)) begin
        r = 18'd65536;
      end else begin
        for (int b = 15; b >= 0; b--) begin
          x = (x * x) >> 30;
          if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            r = r | (18'd1 << b);
          end
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  // 2^(i/N) in Q2.16, from successive square roots of two
  function automatic tbl_t build_exp_tab();
    tbl_t t;
    logic [63:0] roots [LOG_TBL_BITS+1];
    logic [63:0] acc;
    roots[0] = 64'd2 << 30;
    for (int j = 1; j <= LOG_TBL_BITS; j++) roots[j] = isqrt64(roots[j-1] << 30);
    for (int i = 0; i < TBL_SIZE; i++) begin
      acc = 64'd1 << 30;
      for (int j = 0; j <= LOG_TBL_BITS; j++)
        if (((i >> j) & 1) != 0) acc = (acc * roots[LOG_TBL_BITS - j]) >> 30;
      t[i] = 18'((acc + (64'd1 << 13)) >> 14);
    end
    return t;
  endfunction

  localparam tbl_t LOG_TAB = build_log_tab();
  localparam tbl_t EXP_TAB = build_exp_tab();

  // linear interpolation between neighboring table entries
  function automatic logic [17:0] tbl_interp(input tbl_t t, input logic [15:0] frac);
    logic [LOG_TBL_BITS:0] idx;
    logic [FRAC_SH-1:0]    rem;
    logic [17:0]           d;
    logic [17+FRAC_SH:0]   pr;
    idx = {1'b0, frac[15 -: LOG_TBL_BITS]};
    rem = frac[FRAC_SH-1:0];
    d   = t[idx + 1'b1] - t[idx];
    pr  = (18+FRAC_SH)'(d) * (18+FRAC_SH)'(rem);
    return t[idx] + pr[17+FRAC_SH:FRAC_SH];
  endfunction

endpackage

[hdl/bav_if.sv]
// stream interfaces for barometer frames and altitude results
// depends on nothing
interface bav_frame_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] temp_byte_low;
  logic [7:0] temp_byte_mid;
  logic [7:0] temp_byte_high;
  logic [7:0] press_byte_low;
  logic [7:0] press_byte_mid;
  logic [7:0] press_byte_high;
  modport source (output valid, command, temp_byte_low, temp_byte_mid, temp_byte_high,
                  press_byte_low, press_byte_mid, press_byte_high, input ready);
  modport sink (input valid, command, temp_byte_low, temp_byte_mid, temp_byte_high,
                press_byte_low, press_byte_mid, press_byte_high, output ready);
endinterface

interface bav_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] temperature_q16;
  logic        [23:0] pressure_raw;
  logic signed [23:0] altitude_rel;
  logic signed [23:0] ground_altitude;
  logic               calibrated;
  logic               altitude_updated;
  modport source (output valid, temperature_q16, pressure_raw, altitude_rel,
                  ground_altitude, calibrated, altitude_updated, input ready);
  modport sink (input valid, temperature_q16, pressure_raw, altitude_rel,
                ground_altitude, calibrated, altitude_updated, output ready);
endinterface

[hdl/bav_ctrl.sv]
// controller state machine sequencing calibration, division and power steps
// depends on bav_pkg
module bav_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bav_pkg::dp_stat_t stat,
  output bav_pkg::dp_cmd_t  cmd
);
  import bav_pkg::*;

  state_t state, state_next;
  logic   gnd_path, gnd_path_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // state and path registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      gnd_path <= 1'b0;
    end else begin
      state    <= state_next;
      gnd_path <= gnd_path_next;
    end
  end

  // result beat holding flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    gnd_path_next = gnd_path;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.restart_cmd || stat.p_zero) begin
          state_next = ST_DONE;
        end else if (!stat.calibrated) begin
          state_next = stat.cal_done ? ST_AVG_LOAD : ST_DONE;
        end else begin
          state_next    = ST_RATIO_DIV;
          gnd_path_next = 1'b0;
        end
      end
      ST_AVG_LOAD: state_next = ST_AVG_DIV;
      ST_AVG_DIV:  if (stat.div_last) state_next = ST_GND_LOAD;
      ST_GND_LOAD: begin
        state_next    = ST_GND_DIV;
        gnd_path_next = 1'b1;
      end
      ST_GND_DIV:   if (stat.div_last) state_next = ST_SAT;
      ST_RATIO_DIV: if (stat.div_last) state_next = ST_SAT;
      ST_SAT: state_next = (gnd_path || stat.in_band) ? ST_POW_A : ST_DONE;
      ST_POW_A:  state_next = ST_POW_B;
      ST_POW_B:  state_next = ST_POW_C;
      ST_POW_C:  state_next = ST_POW_D;
      ST_POW_D:  state_next = ST_POW_E;
      ST_POW_E:  state_next = ST_POW_F;
      ST_POW_F:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = !rst;
        cmd.load_frame = in_valid && !rst;
      end
      ST_DECIDE: begin
        if (stat.restart_cmd) begin
          cmd.restart = 1'b1;
        end else if (stat.p_zero) begin
          cmd.zero_alt = 1'b1;
        end else if (!stat.calibrated) begin
          cmd.accum    = 1'b1;
          cmd.zero_alt = 1'b1;
        end else begin
          cmd.load_ratio_div = 1'b1;
        end
      end
      ST_AVG_LOAD:  cmd.load_avg_div = 1'b1;
      ST_AVG_DIV:   cmd.div_step = 1'b1;
      ST_GND_LOAD:  cmd.load_gnd_div = 1'b1;
      ST_GND_DIV:   cmd.div_step = 1'b1;
      ST_RATIO_DIV: cmd.div_step = 1'b1;
      ST_SAT:       cmd.load_ratio = 1'b1;
      ST_POW_A:     cmd.pow_a = 1'b1;
      ST_POW_B:     cmd.pow_b = 1'b1;
      ST_POW_C:     cmd.pow_c = 1'b1;
      ST_POW_D:     cmd.pow_d = 1'b1;
      ST_POW_E:     cmd.pow_e = 1'b1;
      ST_POW_F:     cmd.pow_f = 1'b1;
      ST_COMMIT: begin
        cmd.commit_ground = gnd_path;
        cmd.commit_alt    = !gnd_path;
      end
      ST_DONE:  cmd.load_out = out_free;
      default: ;
    endcase
  end

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten while waiting");

  // only one kind of commit per item
  a_one_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit_ground && cmd.commit_alt))
    else $error("ground and altitude commit together");

  // decision follows a fresh frame
  a_decide_after_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.load_frame |=> state == ST_DECIDE)
    else $error("frame not followed by decision");

  // ground altitude only computed on the calibration path
  a_ground_path: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_ground |-> !stat.calibrated)
    else $error("ground commit while calibrated");

endmodule

[hdl/bav_dp.sv]
// datapath: config registers, calibration state, shared restoring divider,
// log2/exp2 power pipeline steps and result registers; depends on bav_pkg
module bav_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bav_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bav_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_command,
  input  logic [23:0]                         in_temp,
  input  logic [23:0]                         in_press,
  input  bav_pkg::dp_cmd_t                    cmd,
  output bav_pkg::dp_stat_t                   stat,
  output logic signed [23:0]                  temperature_q16,
  output logic        [23:0]                  pressure_raw,
  output logic signed [23:0]                  altitude_rel,
  output logic signed [23:0]                  ground_altitude,
  output logic                                calibrated,
  output logic                                altitude_updated
);
  import bav_pkg::*;

  // configuration
  logic [16:0] sea_level;
  logic [15:0] alt_scale;
  logic [15:0] expo;
  logic [9:0]  cal_samples;
  logic [17:0] ratio_low;
  logic [17:0] ratio_high;

  // item and calibration state
  logic               frame_cmd;
  logic [23:0]        frame_temp;
  logic [23:0]        frame_press;
  logic [33:0]        calib_sum;
  logic [9:0]         calib_count;
  logic               is_cal;
  logic [29:0]        ground_p;
  logic signed [23:0] last_alt;
  logic signed [23:0] ground_alt;
  logic               updated;
  logic [9:0]         cnt_inc;

  // divider
  logic [DIV_D_W-1:0]   div_rem;
  logic [DIV_N_W-1:0]   div_quo;
  logic [DIV_D_W-1:0]   div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_D_W:0]     trial;
  logic                 trial_ge;
  logic [DIV_D_W:0]     trial_sub;
  logic [17:0]          ratio_sat;
  logic [34:0]          avg_num;

  // power steps
  logic [17:0]        ratio;
  logic [4:0]         msb_k, msb_next;
  logic [15:0]        mant_frac;
  logic [17:0]        mant_next;
  logic signed [22:0] log_l;
  logic signed [5:0]  k_off;
  logic signed [39:0] ly_prod;
  logic signed [23:0] y_val;
  logic signed [7:0]  exp_n;
  logic [17:0]        exp_v;
  logic [7:0]         neg_n;
  logic [19:0]        pow_v;
  logic signed [20:0] diff;
  logic signed [37:0] alt_prod;
  logic signed [29:0] alt_wide;
  logic signed [23:0] alt_sat;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sea_level   <= 17'd101325;
      alt_scale   <= 16'd44330;
      expo        <= 16'd12471;
      cal_samples <= 10'd100;
      ratio_low   <= 18'd58982;
      ratio_high  <= 18'd78643;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SEA_LEVEL:   sea_level   <= cfg_data[16:0];
        REG_ALT_SCALE:   alt_scale   <= cfg_data[15:0];
        REG_EXPONENT:    expo        <= cfg_data[15:0];
        REG_CAL_SAMPLES: cal_samples <= cfg_data[9:0];
        REG_RATIO_LOW:   ratio_low   <= cfg_data;
        REG_RATIO_HIGH:  ratio_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      frame_cmd   <= in_command;
      frame_temp  <= in_temp;
      frame_press <= in_press;
    end
  end

  assign cnt_inc = calib_count + 10'd1;

  // calibration and altitude state
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_sum   <= '0;
      calib_count <= '0;
      is_cal      <= 1'b0;
      ground_p    <= '0;
      last_alt    <= '0;
      ground_alt  <= '0;
      updated     <= 1'b0;
    end else begin
      if (cmd.load_frame) updated <= 1'b0;
      if (cmd.restart) begin
        calib_sum   <= '0;
        calib_count <= '0;
        is_cal      <= 1'b0;
      end
      if (cmd.zero_alt) last_alt <= '0;
      if (cmd.accum) begin
        calib_sum   <= calib_sum + 34'(frame_press);
        calib_count <= cnt_inc;
      end
      if (cmd.load_gnd_div) ground_p <= div_quo[29:0];
      if (cmd.commit_ground) begin
        ground_alt  <= alt_sat;
        calib_sum   <= '0;
        calib_count <= '0;
        is_cal      <= 1'b1;
      end
      if (cmd.commit_alt) begin
        last_alt <= alt_sat;
        updated  <= 1'b1;
      end
    end
  end

  assign stat.restart_cmd = (frame_cmd == 1'(CMD_RESTART));
  assign stat.p_zero      = (frame_press == 24'd0);
  assign stat.calibrated  = is_cal;
  assign stat.cal_done    = (cnt_inc != 10'd0) && (cnt_inc >= cal_samples);
  assign stat.div_last    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.in_band     = (ratio_sat > ratio_low) && (ratio_sat < ratio_high);

  // restoring divider, one quotient bit per step
  assign avg_num   = 35'(calib_sum) + 35'(calib_count[9:1]);
  assign trial     = {div_rem, div_quo[DIV_N_W-1]};
  assign trial_ge  = trial >= {1'b0, div_den};
  assign trial_sub = trial - {1'b0, div_den};
  assign ratio_sat = (|div_quo[DIV_N_W-1:18]) ? RATIO_MAX : div_quo[17:0];

  always_ff @(posedge clk) begin
    if (cmd.load_avg_div) begin
      div_quo <= DIV_N_W'(avg_num);
      div_den <= DIV_D_W'(calib_count);
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.load_gnd_div) begin
      div_quo <= DIV_N_W'({div_quo[29:0], 10'd0});
      div_den <= DIV_D_W'(sea_level);
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.load_ratio_div) begin
      div_quo <= DIV_N_W'({frame_press, 16'd0});
      div_den <= ground_p;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      div_quo <= {div_quo[DIV_N_W-2:0], trial_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // leading one and normalized mantissa of the ratio
  always_comb begin
    msb_next = '0;
    for (int i = 0; i < 18; i++)
      if (ratio[i]) msb_next = 5'(i);
    if (msb_next <= 5'd16) mant_next = ratio << (5'd16 - msb_next);
    else                   mant_next = ratio >> 1;
  end

  assign k_off    = $signed({1'b0, msb_k}) - 6'sd16;
  assign ly_prod  = 40'(log_l) * 40'(signed'({1'b0, expo}));
  assign neg_n    = -exp_n;
  assign alt_prod = 38'(signed'({1'b0, alt_scale})) * 38'(diff);
  assign alt_sat  = (alt_wide > 30'sd8388607)  ? 24'sh7FFFFF :
                    (alt_wide < -30'sd8388608) ? 24'sh800000 : alt_wide[23:0];

  // power value scaled by the integer part of the exponent
  always_comb begin
    if (ratio == 18'd0)  pow_v = (expo == 16'd0) ? 20'd65536 : 20'd0;
    else if (!exp_n[7])  pow_v = 20'(exp_v) << exp_n[1:0];
    else                 pow_v = 20'(exp_v) >> neg_n[4:0];
  end

  // power r^e = exp2(e * log2 r), one step per command
  always_ff @(posedge clk) begin
    if (cmd.load_ratio) ratio <= ratio_sat;
    if (cmd.pow_a) begin
      msb_k     <= msb_next;
      mant_frac <= mant_next[15:0];
    end
    if (cmd.pow_b)
      log_l <= 23'(signed'({k_off, 16'd0})) + 23'(signed'({5'd0, tbl_interp(LOG_TAB, mant_frac)}));
    if (cmd.pow_c) y_val <= ly_prod[39:16];
    if (cmd.pow_d) begin
      exp_n <= y_val[23:16];
      exp_v <= tbl_interp(EXP_TAB, y_val[15:0]);
    end
    if (cmd.pow_e) diff <= 21'sd65536 - signed'({1'b0, pow_v});
    if (cmd.pow_f) alt_wide <= alt_prod[37:8];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      temperature_q16  <= frame_temp;
      pressure_raw     <= frame_press;
      altitude_rel     <= last_alt;
      ground_altitude  <= ground_alt;
      calibrated       <= is_cal;
      altitude_updated <= updated;
    end
  end

endmodule

[hdl/baro_altitude_with_ground_calibration.sv]
// top level of the barometric altitude block with ground calibration
// depends on bav_pkg, bav_if, bav_ctrl, bav_dp
//
//  port     dir  contents
//  frame    in   command plus six raw barometer bytes
//  result   out  temperature, pressure, altitudes, status flags
//  cfg_*    in   register write: enable, index, data
//
// on restart, zero pressure or a calibration sample that does not complete a
// frame passes idle, decide and done only; a sample outside the ratio band
// adds the 42-step restoring divider and saturate, one inside it also the six
// power steps and commit; completing calibration runs two divisions.
// reset is synchronous and restores the default registers. a finished result
// waits in its register while the next frame is taken; a stalled result
// holds the block in its last step.
module baro_altitude_with_ground_calibration (
  input  logic                            clk,
  input  logic                            rst,
  bav_frame_if.sink                       frame,
  bav_result_if.source                    result,
  input  logic                            cfg_we,
  input  logic [bav_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bav_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bav_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bav_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and state
  bav_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .in_command       (frame.command),
    .in_temp          ({frame.temp_byte_high, frame.temp_byte_mid, frame.temp_byte_low}),
    .in_press         ({frame.press_byte_high, frame.press_byte_mid, frame.press_byte_low}),
    .cmd              (cmd),
    .stat             (stat),
    .temperature_q16  (result.temperature_q16),
    .pressure_raw     (result.pressure_raw),
    .altitude_rel     (result.altitude_rel),
    .ground_altitude  (result.ground_altitude),
    .calibrated       (result.calibrated),
    .altitude_updated (result.altitude_updated)
  );

endmodule
